FILE: hdl/atii_pkg.sv
// attenuation table interpolator package: breakpoint, coefficient and reciprocal tables
// plus the stage enable struct shared by the pipeline modules
// no dependencies
package atii_pkg;

    localparam int NUM_BP  = 12;
    localparam int NUM_SEG = NUM_BP - 1;
    localparam int SEG_W   = 4;

    // clamp limits, Q12.4 meters
    localparam logic [15:0] RANGE_MIN_Q4 = 16'd112;
    localparam logic [15:0] RANGE_MAX_Q4 = 16'd52000;

    // segment index of the last breakpoint
    localparam logic [SEG_W-1:0] LAST_IDX = SEG_W'(NUM_BP - 1);

    // breakpoints, Q12.4 meters
    localparam logic [15:0] BP_Q4 [NUM_BP] = '{
        16'd112, 16'd208, 16'd320, 16'd512, 16'd800, 16'd1040,
        16'd1600, 16'd2560, 16'd3200, 16'd5200, 16'd9600, 16'd52000
    };

    // linear coefficients, Q2.30
    localparam logic [31:0] LIN_TAB [NUM_BP] = '{
        32'd751619277, 32'd375809638, 32'd236223201, 32'd150323855,
        32'd96636764, 32'd75161928, 32'd48318382, 32'd28991029,
        32'd23622320, 32'd15032386, 32'd7516193, 32'd1503239
    };

    // quadratic coefficients, Q2.30
    localparam logic [31:0] QUAD_TAB [NUM_BP] = '{
        32'd1932735283, 32'd472446403, 32'd214748365, 32'd75161928,
        32'd34359738, 32'd18253611, 32'd8053064, 32'd3006477,
        32'd2040109, 32'd751619, 32'd214748, 32'd7516
    };

    // per-segment reciprocal of the span, round(2^32 / span)
    localparam logic [25:0] RECIP_TAB [NUM_SEG] = '{
        26'd44739243, 26'd38347922, 26'd22369621, 26'd14913081,
        26'd17895697, 26'd7669584, 26'd4473924, 26'd6710886,
        26'd2147484, 26'd976129, 26'd101296
    };

    // fraction t, Q0.24 with room for exactly 1.0
    localparam int T_W = 25;

    // load enables for the five pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

FILE: hdl/attenuation_table_interpolator_unit.sv
// attenuation table interpolator top level: handshake, stage valid chain, table fetch
// depends on atii_pkg, atii_seg, atii_frac, atii_lerp
//
// Usage:
//   Input channel s_valid/s_ready/s_range_q4 carries one light range per beat,
//   unsigned Q12.4 meters. Result channel m_valid/m_ready carries the linear
//   and quadratic attenuation coefficients, unsigned Q2.30, one beat per input.
//   The range is clamped to 7 m .. 3250 m and the coefficients are linearly
//   interpolated between fixed table entries.
//   Pipeline: five register stages (segment search, reciprocal multiply,
//   fraction rounding and table fetch, coefficient multiply, rounded add
//   into the output register) lie between an accepted input beat and m_valid.
//   Throughput: one beat per cycle while m_ready stays high.
//   Stall: a low m_ready holds the output register; stages upstream keep
//   filling empty slots, and s_ready drops only when all five stages hold
//   a beat. Nothing is dropped or repeated.
//   Reset: aresetn low clears all stage valid bits; no result is pending
//   afterwards and s_ready is high.
module attenuation_table_interpolator_unit
    import atii_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_range_q4,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_linear_coeff,
    output logic [31:0] m_quadratic_coeff
);

    logic [4:0]       v_reg;
    logic [4:0]       v_next;
    logic [4:0]       rdy;
    stage_en_t        en;
    logic [15:0]      off1;
    logic [SEG_W-1:0] seg1;
    logic             sat1;
    logic [SEG_W-1:0] seg2;
    logic             sat2;
    logic [T_W-1:0]   t3;
    logic [SEG_W-1:0] lo_idx;
    logic [SEG_W-1:0] hi_idx;

    // a stage takes a beat when it is empty or its content moves on
    always_comb begin
        rdy[4] = !v_reg[4] || m_ready;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        en.s1 = rdy[0];
        en.s2 = rdy[1];
        en.s3 = rdy[2];
        en.s4 = rdy[3];
        en.s5 = rdy[4];
    end

    // valid bits follow the data
    always_comb begin
        v_next[0] = rdy[0] ? s_valid : v_reg[0];
        for (int k = 1; k < 5; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[4];

    atii_seg u_seg (
        .aclk     (aclk),
        .en       (en),
        .range_q4 (s_range_q4),
        .off_reg  (off1),
        .seg_reg  (seg1),
        .sat_reg  (sat1)
    );

    atii_frac u_frac (
        .aclk     (aclk),
        .en       (en),
        .off      (off1),
        .seg      (seg1),
        .sat      (sat1),
        .seg2_reg (seg2),
        .sat2_reg (sat2),
        .t_reg    (t3)
    );

    // bracketing entries; a saturated range uses the last entry on both sides
    always_comb begin
        lo_idx = sat2 ? LAST_IDX : seg2;
        hi_idx = sat2 ? LAST_IDX : (seg2 + SEG_W'(1));
    end

    atii_lerp u_lerp_lin (
        .aclk      (aclk),
        .en        (en),
        .lo_in     (LIN_TAB[lo_idx]),
        .hi_in     (LIN_TAB[hi_idx]),
        .t         (t3),
        .coeff_reg (m_linear_coeff)
    );

    atii_lerp u_lerp_quad (
        .aclk      (aclk),
        .en        (en),
        .lo_in     (QUAD_TAB[lo_idx]),
        .hi_in     (QUAD_TAB[hi_idx]),
        .t         (t3),
        .coeff_reg (m_quadratic_coeff)
    );

endmodule

FILE: hdl/atii_seg.sv
// stage one: range clamp, segment search and offset into the segment
// depends on atii_pkg
module atii_seg
    import atii_pkg::*;
(
    input  logic             aclk,
    input  stage_en_t        en,
    input  logic [15:0]      range_q4,
    output logic [15:0]      off_reg,
    output logic [SEG_W-1:0] seg_reg,
    output logic             sat_reg
);

    logic [15:0]      d_clamp;
    logic [SEG_W-1:0] seg_next;
    logic [15:0]      off_next;
    logic             sat_next;

    // clamp to the bottom breakpoint, flag the top
    always_comb begin
        d_clamp  = (range_q4 < RANGE_MIN_Q4) ? RANGE_MIN_Q4 : range_q4;
        sat_next = (range_q4 >= RANGE_MAX_Q4);
    end

    // last breakpoint not above the range, the top breakpoint excluded
    always_comb begin
        seg_next = '0;
        for (int i = 1; i < NUM_SEG; i++) begin
            if (d_clamp >= BP_Q4[i]) begin
                seg_next = SEG_W'(i);
            end
        end
        off_next = d_clamp - BP_Q4[seg_next];
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            off_reg <= off_next;
            seg_reg <= seg_next;
            sat_reg <= sat_next;
        end
    end

endmodule

FILE: hdl/atii_frac.sv
// stages two and three: offset times segment reciprocal, then rounding to the Q0.24 fraction
// depends on atii_pkg
module atii_frac
    import atii_pkg::*;
(
    input  logic             aclk,
    input  stage_en_t        en,
    input  logic [15:0]      off,
    input  logic [SEG_W-1:0] seg,
    input  logic             sat,
    output logic [SEG_W-1:0] seg2_reg,
    output logic             sat2_reg,
    output logic [T_W-1:0]   t_reg
);

    logic [41:0] prod_reg;
    logic [41:0] prod_next;
    logic [41:0] prod_rnd;

    // offset scaled by the stored reciprocal
    always_comb begin
        prod_next = 42'(off) * 42'(RECIP_TAB[seg]);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            prod_reg <= prod_next;
            seg2_reg <= seg;
            sat2_reg <= sat;
        end
    end

    // round away the low 8 bits; the product stays below 2^32 for an unsaturated range
    always_comb begin
        prod_rnd = prod_reg + 42'd128;
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            t_reg <= prod_rnd[32:8];
        end
    end

endmodule

FILE: hdl/atii_lerp.sv
// one interpolation lane: coefficient delta, delta times fraction, rounded add
// depends on atii_pkg
module atii_lerp
    import atii_pkg::*;
(
    input  logic           aclk,
    input  stage_en_t      en,
    input  logic [31:0]    lo_in,
    input  logic [31:0]    hi_in,
    input  logic [T_W-1:0] t,
    output logic [31:0]    coeff_reg
);

    logic signed [32:0] delta_reg;
    logic signed [32:0] delta_next;
    logic [31:0]        lo3_reg;
    logic [31:0]        lo4_reg;
    logic signed [58:0] p_reg;
    logic signed [58:0] p_next;
    logic [58:0]        mag;
    logic [58:0]        mag_rnd;
    logic [31:0]        r;
    logic [31:0]        coeff_next;

    // stage three: signed coefficient delta
    always_comb begin
        delta_next = $signed({1'b0, hi_in}) - $signed({1'b0, lo_in});
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            delta_reg <= delta_next;
            lo3_reg   <= lo_in;
        end
    end

    // stage four: delta times fraction
    always_comb begin
        p_next = 59'(delta_reg) * 59'($signed({1'b0, t}));
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            p_reg   <= p_next;
            lo4_reg <= lo3_reg;
        end
    end

    // stage five: round magnitude to nearest, ties away from zero, then apply sign
    always_comb begin
        mag        = p_reg[58] ? 59'(-p_reg) : 59'(p_reg);
        mag_rnd    = mag + 59'h80_0000;
        r          = mag_rnd[55:24];
        coeff_next = p_reg[58] ? (lo4_reg - r) : (lo4_reg + r);
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            coeff_reg <= coeff_next;
        end
    end

endmodule

FILE: hdl/atii_check.sv
// port-level checker for the attenuation table interpolator, bound to the top level
// depends on attenuation_table_interpolator_unit
module atii_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [15:0] s_range_q4,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_linear_coeff,
    input logic [31:0] m_quadratic_coeff
);

    // nothing pending right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat pending after reset");

    // input back-pressure only comes from a stalled, full output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_linear_coeff) && $stable(m_quadratic_coeff)))
        else $error("stalled result beat changed");

    // interpolated values never exceed the first table entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_linear_coeff <= 32'd751619277 &&
                     m_quadratic_coeff <= 32'd1932735283))
        else $error("coefficient above table maximum");

endmodule

bind attenuation_table_interpolator_unit atii_check u_atii_check (.*);

FILE: verif/attenuation_table_interpolator_unit_test.sv
// testbench for attenuation_table_interpolator_unit: random and directed ranges with
// randomized sender gaps and receiver stalls, coefficients checked against a local predictor
// depends on atii_pkg and the attenuation_table_interpolator_unit rtl
module attenuation_table_interpolator_unit_test
    import atii_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES      = 4;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct {
        logic [31:0] linear;
        logic [31:0] quadratic;
    } coeff_pair_t;

    // expected coefficient store and compare
    class coeff_scoreboard;
        coeff_pair_t pending_coeffs[$];
        int          error_count;

        function new();
            error_count = 0;
        endfunction

        // rounded interpolation between two q2.30 entries, frac is q0.24
        function logic [31:0] blend_q30(logic [31:0] lo, logic [31:0] hi, logic [63:0] frac);
            longint      delta;
            longint      prod;
            logic [63:0] mag;
            logic [63:0] rnd;
            logic [63:0] sum;
            delta = longint'({32'd0, hi}) - longint'({32'd0, lo});
            prod  = delta * longint'(frac);
            mag   = (prod < 0) ? 64'(-prod) : 64'(prod);
            rnd   = (mag + 64'd8388608) >> 24;
            sum   = (prod < 0) ? ({32'd0, lo} - rnd) : ({32'd0, lo} + rnd);
            return sum[31:0];
        endfunction

        function coeff_pair_t predict_coeffs(logic [15:0] range_q4);
            coeff_pair_t res;
            logic [15:0] clamp_q4;
            int          seg;
            logic [63:0] frac;
            clamp_q4 = (range_q4 < RANGE_MIN_Q4) ? RANGE_MIN_Q4 : range_q4;
            // far end of the table is returned as is
            if (clamp_q4 >= RANGE_MAX_Q4) begin
                res.linear    = LIN_TAB[NUM_BP-1];
                res.quadratic = QUAD_TAB[NUM_BP-1];
                return res;
            end
            seg = 0;
            for (int i = 1; i < NUM_BP - 1; i++) begin
                if (clamp_q4 >= BP_Q4[i]) seg = i;
            end
            frac = (64'(clamp_q4 - BP_Q4[seg]) * 64'(RECIP_TAB[seg]) + 64'd128) >> 8;
            res.linear    = blend_q30(LIN_TAB[seg], LIN_TAB[seg+1], frac);
            res.quadratic = blend_q30(QUAD_TAB[seg], QUAD_TAB[seg+1], frac);
            return res;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        task note_input(logic [15:0] range_q4);
            pending_coeffs.push_back(predict_coeffs(range_q4));
        endtask

        task check_result(logic [31:0] linear, logic [31:0] quadratic);
            coeff_pair_t exp_pair;
            if (pending_coeffs.size() == 0) begin
                report($sformatf("result beat with nothing expected: lin %0d quad %0d",
                                 linear, quadratic));
                return;
            end
            exp_pair = pending_coeffs.pop_front();
            if (linear !== exp_pair.linear)
                report($sformatf("linear_coeff got %0d expected %0d",
                                 linear, exp_pair.linear));
            if (quadratic !== exp_pair.quadratic)
                report($sformatf("quadratic_coeff got %0d expected %0d",
                                 quadratic, exp_pair.quadratic));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_range_q4;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_linear_coeff;
    logic [31:0] m_quadratic_coeff;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    coeff_scoreboard sb;

    attenuation_table_interpolator_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_range_q4        (s_range_q4),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_linear_coeff    (m_linear_coeff),
        .m_quadratic_coeff (m_quadratic_coeff)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitors on both channels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_range_q4);
        if (aresetn && m_valid && m_ready) sb.check_result(m_linear_coeff, m_quadratic_coeff);
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // one input beat, with random idle cycles ahead of it
    task send_range(input logic [15:0] range_q4);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_range_q4 <= range_q4;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // mostly in-table ranges, plus breakpoint neighbors, clamp regions and raw noise
    function logic [15:0] pick_range();
        int sel;
        int seg;
        int span;
        sel = $urandom_range(99);
        if (sel < 55) begin
            seg  = $urandom_range(NUM_SEG - 1);
            span = int'(BP_Q4[seg+1]) - int'(BP_Q4[seg]);
            return 16'(int'(BP_Q4[seg]) + $urandom_range(span - 1));
        end else if (sel < 70) begin
            seg = $urandom_range(NUM_BP - 1);
            return 16'(int'(BP_Q4[seg]) + int'($urandom_range(6)) - 3);
        end else if (sel < 80) begin
            return 16'($urandom_range(int'(RANGE_MIN_Q4) - 1));
        end else if (sel < 88) begin
            return 16'($urandom_range(65535, int'(RANGE_MAX_Q4)));
        end
        return 16'($urandom_range(65535));
    endfunction

    logic [15:0] directed_ranges[$];

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_range_q4     = 16'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // zero, clamp edges, every breakpoint, just under some, bit patterns
        directed_ranges = '{16'd0, 16'd1, 16'd111, 16'd112, 16'd113, 16'd207, 16'd208,
                            16'd320, 16'd512, 16'd800, 16'd1040, 16'd1600, 16'd2560,
                            16'd3200, 16'd5199, 16'd5200, 16'd9600, 16'd51999, 16'd52000,
                            16'd52001, 16'd65535, 16'h5555, 16'haaaa};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_ranges[i]) send_range(directed_ranges[i]);

        // idling phases: none, sender gaps, receiver stalls, both
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_range(pick_range());
        end
        s_valid <= 1'b0;

        // drain, then let any stray beat show up
        while (sb.pending_coeffs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/atii_pkg.sv
hdl/atii_seg.sv
hdl/atii_frac.sv
hdl/atii_lerp.sv
hdl/attenuation_table_interpolator_unit.sv
hdl/atii_check.sv
verif/attenuation_table_interpolator_unit_test.sv
